[hdl/hoct_pkg.sv]
// ----------------------------------------------------------------------------
// hoct_pkg
// Shared types, constants and helpers for the half-open connection table.
// ----------------------------------------------------------------------------
package hoct_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int TIME_BITS_DEF = 48;

    localparam int ID_W    = 64;
    localparam int KEY_W   = 64;
    localparam int LIMIT_W = 7;
    localparam int CNT_W   = 7;
    localparam int EVICT_W = 32;
    localparam int APB_DW  = 64;
    localparam int APB_AW  = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd64;
    localparam logic [63:0]        AGE_RST   = 64'd1000000000;
    localparam logic [31:0]        CNT_MAX   = 32'((1 << CNT_W) - 1);

    typedef enum logic [1:0] {
        REQ_OPEN      = 2'd0,
        REQ_ESTABLISH = 2'd1,
        REQ_CLOSE     = 2'd2,
        REQ_EXPIRE    = 2'd3
    } t_req;

    typedef enum logic {
        REG_TABLE_LIMIT = 1'b0,
        REG_MAX_AGE     = 1'b1
    } t_reg_sel;

    typedef struct packed {
        logic [ID_W-1:0]    new_id;
        logic               ok;
        logic               evicted;
        logic [CNT_W-1:0]   removed_count;
        logic [CNT_W-1:0]   live_count;
        logic [CNT_W-1:0]   established_count;
        logic [CNT_W-1:0]   peak_count;
        logic [EVICT_W-1:0] eviction_total;
    } t_result;

    // Clamp a count to the largest value the result field can carry
    function automatic logic [CNT_W-1:0] sat_count(input logic [31:0] v);
        logic [CNT_W-1:0] res;
        res = (v > CNT_MAX) ? CNT_MAX[CNT_W-1:0] : v[CNT_W-1:0];
        return res;
    endfunction

endpackage

[hdl/hoct_regs.sv]
// ----------------------------------------------------------------------------
// hoct_regs
// APB register bank: table limit and half-open expiry age.
// ----------------------------------------------------------------------------
module hoct_regs
    import hoct_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready,
    output logic [LIMIT_W-1:0]   o_table_limit,
    output logic [TIME_BITS-1:0] o_max_age
);

    logic [LIMIT_W-1:0]   r_table_limit, n_table_limit;
    logic [TIME_BITS-1:0] r_max_age, n_max_age;
    logic                 w_write;
    t_reg_sel             w_sel;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite;
    assign w_sel   = t_reg_sel'(paddr[3]);

    always_comb begin
        n_table_limit = r_table_limit;
        n_max_age     = r_max_age;
        if (w_write) begin
            case (w_sel)
                REG_TABLE_LIMIT: n_table_limit = pwdata[LIMIT_W-1:0];
                REG_MAX_AGE:     n_max_age     = pwdata[TIME_BITS-1:0];
                default:         n_table_limit = r_table_limit;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_limit <= LIMIT_RST;
            r_max_age     <= AGE_RST[TIME_BITS-1:0];
        end else begin
            r_table_limit <= n_table_limit;
            r_max_age     <= n_max_age;
        end
    end

    // Read back the selected register
    always_comb begin
        case (w_sel)
            REG_TABLE_LIMIT: prdata = APB_DW'(r_table_limit);
            REG_MAX_AGE:     prdata = APB_DW'(r_max_age);
            default:         prdata = '0;
        endcase
    end

    assign o_table_limit = r_table_limit;
    assign o_max_age     = r_max_age;

endmodule

[hdl/hoct_engine.sv]
// ----------------------------------------------------------------------------
// hoct_engine
// Slot memory and the sequencer that sweeps it for each transaction.
// ----------------------------------------------------------------------------
module hoct_engine
    import hoct_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_req_type,
    input  logic [KEY_W-1:0]     i_source_key,
    input  logic [TIME_BITS-1:0] i_timestamp,
    input  logic [ID_W-1:0]      i_conn_id,
    input  logic [LIMIT_W-1:0]   i_table_limit,
    input  logic [TIME_BITS-1:0] i_max_age,
    input  logic                 i_out_free,
    output logic                 o_load,
    output t_result              o_res
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int LW    = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int MW    = 2 + ID_W + KEY_W + TIME_BITS;
    localparam int I_LO  = TIME_BITS + KEY_W;
    localparam int E_BIT = I_LO + ID_W;
    localparam int V_BIT = E_BIT + 1;
    localparam logic [AW:0] CNT_END  = (AW + 1)'(DEPTH);
    localparam logic [AW:0] CNT_LAST = (AW + 1)'(DEPTH - 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SWEEP = 6'b000100,
        S_APPLY = 6'b001000,
        S_EVICT = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    // Slot word: {valid, established, id, source, open time}
    logic [MW-1:0] r_mem [DEPTH];
    logic [MW-1:0] r_rd;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [MW-1:0] w_wdata;

    t_state               r_state, n_state;
    logic [AW:0]          r_cnt, n_cnt;
    logic [AW-1:0]        r_prev, n_prev;
    t_req                 r_req, n_req;
    logic [KEY_W-1:0]     r_src, n_src;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic [ID_W-1:0]      r_conn_id, n_conn_id;
    logic                 r_scan, n_scan;
    logic                 r_free_found, n_free_found;
    logic [AW-1:0]        r_free_idx, n_free_idx;
    logic                 r_vic_found, n_vic_found;
    logic [AW-1:0]        r_vic_idx, n_vic_idx;
    logic [TIME_BITS-1:0] r_vic_time, n_vic_time;
    logic [ID_W-1:0]      r_vic_id, n_vic_id;
    logic                 r_hit, n_hit;
    logic [AW-1:0]        r_hit_idx, n_hit_idx;
    logic [MW-1:0]        r_hit_word, n_hit_word;
    logic [CW-1:0]        r_removed, n_removed;
    logic [CW-1:0]        r_live, n_live;
    logic [CW-1:0]        r_est, n_est;
    logic [CW-1:0]        r_peak, n_peak;
    logic [EVICT_W-1:0]   r_evc, n_evc;
    logic [ID_W-1:0]      r_next_id, n_next_id;
    logic [ID_W-1:0]      r_new_id, n_new_id;
    logic                 r_ok, n_ok;
    logic                 r_evicted, n_evicted;

    logic                 e_valid, e_est;
    logic [ID_W-1:0]      e_id;
    logic [TIME_BITS-1:0] e_time;
    logic [LW-1:0]        w_lim_ext, w_eff_limit;
    logic                 w_has_free;
    logic [AW-1:0]        w_slot;
    logic [ID_W-1:0]      w_id_inc;
    logic [EVICT_W-1:0]   w_evc_inc;

    assign e_valid = r_rd[V_BIT];
    assign e_est   = r_rd[E_BIT];
    assign e_id    = r_rd[I_LO +: ID_W];
    assign e_time  = r_rd[TIME_BITS-1:0];

    // Limit 0 behaves as 1, anything above DEPTH as DEPTH
    assign w_lim_ext = LW'(i_table_limit);
    always_comb begin
        if (w_lim_ext == '0) begin
            w_eff_limit = LW'(1);
        end else if (w_lim_ext > LW'(DEPTH)) begin
            w_eff_limit = LW'(DEPTH);
        end else begin
            w_eff_limit = w_lim_ext;
        end
    end

    // Lowest free slot once the victim (if any) has gone
    assign w_has_free = r_free_found || r_vic_found;
    assign w_slot     = (r_vic_found && (!r_free_found || r_vic_idx < r_free_idx)) ?
                        r_vic_idx : r_free_idx;
    assign w_id_inc   = r_next_id + ID_W'(1);
    assign w_evc_inc  = (r_evc != '1) ? r_evc + EVICT_W'(1) : r_evc;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_prev       = r_prev;
        n_req        = r_req;
        n_src        = r_src;
        n_now        = r_now;
        n_conn_id    = r_conn_id;
        n_scan       = r_scan;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_vic_found  = r_vic_found;
        n_vic_idx    = r_vic_idx;
        n_vic_time   = r_vic_time;
        n_vic_id     = r_vic_id;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_hit_word   = r_hit_word;
        n_removed    = r_removed;
        n_live       = r_live;
        n_est        = r_est;
        n_peak       = r_peak;
        n_evc        = r_evc;
        n_next_id    = r_next_id;
        n_new_id     = r_new_id;
        n_ok         = r_ok;
        n_evicted    = r_evicted;
        w_we         = 1'b0;
        w_waddr      = r_prev;
        w_wdata      = '0;
        w_raddr      = '0;
        o_load       = 1'b0;

        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_cnt[AW-1:0];
                n_cnt   = r_cnt + (AW + 1)'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_valid) begin
                    n_req        = t_req'(i_req_type);
                    n_src        = i_source_key;
                    n_now        = i_timestamp;
                    n_conn_id    = i_conn_id;
                    n_scan       = LW'(r_live) >= w_eff_limit;
                    n_cnt        = '0;
                    n_free_found = 1'b0;
                    n_vic_found  = 1'b0;
                    n_hit        = 1'b0;
                    n_removed    = '0;
                    n_state      = S_SWEEP;
                end
            end

            S_SWEEP: begin
                // Read slot r_cnt; examine slot r_prev returned by the last read
                w_raddr = (r_cnt == CNT_END) ? '0 : r_cnt[AW-1:0];
                n_prev  = r_cnt[AW-1:0];
                n_cnt   = r_cnt + (AW + 1)'(1);
                if (r_cnt != '0) begin
                    case (r_req)
                        REQ_OPEN: begin
                            if (!r_free_found && !e_valid) begin
                                n_free_found = 1'b1;
                                n_free_idx   = r_prev;
                            end
                            if (r_scan && e_valid && !e_est &&
                                (!r_vic_found || e_time < r_vic_time ||
                                 (e_time == r_vic_time && e_id < r_vic_id))) begin
                                n_vic_found = 1'b1;
                                n_vic_idx   = r_prev;
                                n_vic_time  = e_time;
                                n_vic_id    = e_id;
                            end
                        end
                        REQ_ESTABLISH, REQ_CLOSE: begin
                            if (!r_hit && e_valid && r_conn_id != '0 && e_id == r_conn_id) begin
                                n_hit      = 1'b1;
                                n_hit_idx  = r_prev;
                                n_hit_word = r_rd;
                            end
                        end
                        REQ_EXPIRE: begin
                            if (e_valid && !e_est && r_now > e_time &&
                                (r_now - e_time) > i_max_age) begin
                                w_we      = 1'b1;
                                w_waddr   = r_prev;
                                n_removed = r_removed + CW'(1);
                                n_live    = r_live - CW'(1);
                                n_evc     = w_evc_inc;
                            end
                        end
                        default: n_hit = r_hit;
                    endcase
                end
                if (r_cnt == CNT_END) begin
                    n_state = S_APPLY;
                end
            end

            S_APPLY: begin
                n_new_id  = '0;
                n_ok      = 1'b0;
                n_evicted = 1'b0;
                n_state   = S_DONE;
                case (r_req)
                    REQ_OPEN: begin
                        if (!(r_scan && !r_vic_found)) begin
                            n_evicted = r_vic_found;
                            if (r_vic_found) begin
                                n_evc = w_evc_inc;
                            end
                            if (w_has_free) begin
                                w_we      = 1'b1;
                                w_waddr   = w_slot;
                                w_wdata   = {1'b1, 1'b0, r_next_id, r_src, r_now};
                                n_new_id  = r_next_id;
                                n_ok      = 1'b1;
                                n_next_id = (w_id_inc == '0) ? ID_W'(1) : w_id_inc;
                                if (!r_vic_found) begin
                                    n_live = r_live + CW'(1);
                                    if (r_live + CW'(1) > r_peak) begin
                                        n_peak = r_live + CW'(1);
                                    end
                                end
                            end
                            // Victim not reused for the new entry: drop it next
                            if (r_vic_found && r_vic_idx != w_slot) begin
                                n_state = S_EVICT;
                            end
                        end
                    end
                    REQ_ESTABLISH: begin
                        if (r_hit && !r_hit_word[E_BIT]) begin
                            w_we           = 1'b1;
                            w_waddr        = r_hit_idx;
                            w_wdata        = r_hit_word;
                            w_wdata[E_BIT] = 1'b1;
                            n_est          = r_est + CW'(1);
                            n_ok           = 1'b1;
                        end
                    end
                    REQ_CLOSE: begin
                        if (r_hit) begin
                            w_we    = 1'b1;
                            w_waddr = r_hit_idx;
                            n_live  = r_live - CW'(1);
                            n_ok    = 1'b1;
                            if (r_hit_word[E_BIT]) begin
                                n_est = r_est - CW'(1);
                            end
                        end
                    end
                    REQ_EXPIRE: n_ok = 1'b1;
                    default:    n_ok = 1'b0;
                endcase
            end

            S_EVICT: begin
                w_we    = 1'b1;
                w_waddr = r_vic_idx;
                n_state = S_DONE;
            end

            S_DONE: begin
                if (i_out_free) begin
                    o_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cnt     <= '0;
            r_live    <= '0;
            r_est     <= '0;
            r_peak    <= '0;
            r_evc     <= '0;
            r_next_id <= ID_W'(1);
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_live    <= n_live;
            r_est     <= n_est;
            r_peak    <= n_peak;
            r_evc     <= n_evc;
            r_next_id <= n_next_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev       <= n_prev;
        r_req        <= n_req;
        r_src        <= n_src;
        r_now        <= n_now;
        r_conn_id    <= n_conn_id;
        r_scan       <= n_scan;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_vic_found  <= n_vic_found;
        r_vic_idx    <= n_vic_idx;
        r_vic_time   <= n_vic_time;
        r_vic_id     <= n_vic_id;
        r_hit        <= n_hit;
        r_hit_idx    <= n_hit_idx;
        r_hit_word   <= n_hit_word;
        r_removed    <= n_removed;
        r_new_id     <= n_new_id;
        r_ok         <= n_ok;
        r_evicted    <= n_evicted;
    end

    assign o_stall = (r_state != S_IDLE);

    assign o_res.new_id            = r_new_id;
    assign o_res.ok                = r_ok;
    assign o_res.evicted           = r_evicted;
    assign o_res.removed_count     = sat_count(32'(r_removed));
    assign o_res.live_count        = sat_count(32'(r_live));
    assign o_res.established_count = sat_count(32'(r_est));
    assign o_res.peak_count        = sat_count(32'(r_peak));
    assign o_res.eviction_total    = r_evc;

endmodule

[hdl/hoct_outreg.sv]
// ----------------------------------------------------------------------------
// hoct_outreg
// Result register between the sequencer and the output channel.
// ----------------------------------------------------------------------------
module hoct_outreg
    import hoct_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid, n_valid;
    t_result r_res;

    assign o_free  = !r_valid || !i_stall;
    assign n_valid = i_load || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

[hdl/half_open_connection_table_top.sv]
// ----------------------------------------------------------------------------
// half_open_connection_table_top
// Bounded connection table with eviction of the oldest half-open entry.
// ----------------------------------------------------------------------------
// Each transaction is one request (open, establish, close or expire) and gives
// exactly one result carrying the table counters after it. All slots live in a
// single synchronous memory, and every request sweeps it once, slot by slot:
// after the sweep the sequencer applies the request, drops an evicted victim
// in a further state when an open did not reuse its slot for the new entry,
// and then loads the result into the output register once that is free, which
// raises o_valid. The request rate is set by the one memory read port walking
// every slot. One transaction is worked on at a time; i_valid is taken again
// once the result sits in the output register, even if the consumer still
// stalls it. After reset the block clears the memory slot by slot, holding
// o_stall high meanwhile; configuration writes are taken throughout. Ties for
// the oldest half-open entry go to the lowest id, then the lowest slot. Counts
// saturate at 127.
// ----------------------------------------------------------------------------
module half_open_connection_table_top
    import hoct_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_req_type,
    input  logic [KEY_W-1:0]     i_source_key,
    input  logic [TIME_BITS-1:0] i_timestamp,
    input  logic [ID_W-1:0]      i_conn_id,
    // result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [ID_W-1:0]      o_new_id,
    output logic                 o_ok,
    output logic                 o_evicted,
    output logic [CNT_W-1:0]     o_removed_count,
    output logic [CNT_W-1:0]     o_live_count,
    output logic [CNT_W-1:0]     o_established_count,
    output logic [CNT_W-1:0]     o_peak_count,
    output logic [EVICT_W-1:0]   o_eviction_total,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    logic [LIMIT_W-1:0]   w_table_limit;
    logic [TIME_BITS-1:0] w_max_age;
    logic                 w_out_free;
    logic                 w_load;
    t_result              w_res;
    t_result              w_out_res;

    // Register bank: table_limit at byte 0, max_half_open_age at byte 8
    hoct_regs #(
        .TIME_BITS (TIME_BITS)
    ) u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_table_limit (w_table_limit),
        .o_max_age     (w_max_age)
    );

    // Slot memory plus sweep sequencer; holds the live counters too
    hoct_engine #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_source_key  (i_source_key),
        .i_timestamp   (i_timestamp),
        .i_conn_id     (i_conn_id),
        .i_table_limit (w_table_limit),
        .i_max_age     (w_max_age),
        .i_out_free    (w_out_free),
        .o_load        (w_load),
        .o_res         (w_res)
    );

    // Hold the finished result here so the engine can take the next request
    hoct_outreg u_outreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_res   (w_res),
        .i_stall (i_stall),
        .o_free  (w_out_free),
        .o_valid (o_valid),
        .o_res   (w_out_res)
    );

    assign o_new_id            = w_out_res.new_id;
    assign o_ok                = w_out_res.ok;
    assign o_evicted           = w_out_res.evicted;
    assign o_removed_count     = w_out_res.removed_count;
    assign o_live_count        = w_out_res.live_count;
    assign o_established_count = w_out_res.established_count;
    assign o_peak_count        = w_out_res.peak_count;
    assign o_eviction_total    = w_out_res.eviction_total;

endmodule

[hdl/hoct_checker.sv]
// ----------------------------------------------------------------------------
// hoct_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module hoct_checker
    import hoct_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic [ID_W-1:0]    o_new_id,
    input logic               o_ok,
    input logic               o_evicted,
    input logic [CNT_W-1:0]   o_live_count,
    input logic [CNT_W-1:0]   o_established_count,
    input logic [CNT_W-1:0]   o_peak_count,
    input logic [EVICT_W-1:0] o_eviction_total
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_new_id) && $stable(o_live_count))
        else $error("stalled result changed");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_established_count <= o_live_count && o_live_count <= o_peak_count)
        else $error("counter ordering broken");

    // An eviction always makes room for the new entry
    a_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_evicted |-> o_ok && o_new_id != '0)
        else $error("eviction without a granted id");

    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_valid) && o_valid |->
            o_eviction_total >= $past(o_eviction_total))
        else $error("eviction total went down");

endmodule

bind half_open_connection_table_top hoct_checker u_hoct_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_valid             (o_valid),
    .i_stall             (i_stall),
    .o_new_id            (o_new_id),
    .o_ok                (o_ok),
    .o_evicted           (o_evicted),
    .o_live_count        (o_live_count),
    .o_established_count (o_established_count),
    .o_peak_count        (o_peak_count),
    .o_eviction_total    (o_eviction_total)
);
